/* rtl/vqdm_pkg.sv */
package vqdm_pkg;

    localparam logic [1:0] CMD_ALLOC    = 2'd0;
    localparam logic [1:0] CMD_PUBLISH  = 2'd1;
    localparam logic [1:0] CMD_RELEASE  = 2'd2;
    localparam logic [1:0] CMD_COMPLETE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic REG_QSIZE = 1'b0;
    localparam logic REG_AUTO  = 1'b1;

    localparam logic [1:0] FLAG_NEXT = 2'b01;

    // controller to datapath
    typedef struct packed {
        logic start;      // latch item, begin lookup
        logic rebuild;    // start table rebuild sweep
        logic alloc;      // commit allocate
        logic publish;    // commit publish
        logic walk_step;  // release current walk descriptor
        logic finish;     // capture result
    } vqdm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       rebuild_busy;
        logic [1:0] cmd;
        logic       head_bad;
        logic       empty;
        logic       walk;       // command wants a chain walk
        logic       walk_done;  // current step ends the walk
    } vqdm_stat_t;

endpackage

/* rtl/vqdm_datapath.sv */
module vqdm_datapath
    import vqdm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  vqdm_cmd_t   ctl,
    output vqdm_stat_t  stat,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic [1:0]  command,
    input  logic [63:0] buf_addr,
    input  logic [31:0] buf_len,
    input  logic [1:0]  desc_flags,
    input  logic [7:0]  next_index,
    input  logic [7:0]  desc_index,
    input  logic [31:0] used_len,
    output logic [1:0]  status,
    output logic [7:0]  index,
    output logic [31:0] length,
    output logic [8:0]  released,
    output logic [8:0]  free_count,
    output logic [15:0] avail_idx
);

    localparam int TD = (QUEUE_DEPTH < 256) ? QUEUE_DEPTH : 256;
    localparam int TW = $clog2(TD);

    logic [63:0] addr_mem [TD];
    logic [31:0] len_mem  [TD];
    logic [1:0]  flag_mem [TD];
    logic [7:0]  link_mem [TD];
    logic [7:0]  ring_mem [TD];

    logic [3:0]  qlog_reg;
    logic        auto_reg;
    logic [8:0]  n_val;
    logic [7:0]  mask;
    logic        rb_busy_reg;
    logic [TW-1:0] rb_ptr_reg;

    logic [1:0]  cmd_reg;
    logic [63:0] addr_reg;
    logic [31:0] blen_reg;
    logic [1:0]  fl_reg;
    logic [7:0]  nx_reg;
    logic [7:0]  head_reg;
    logic [31:0] ulen_reg;

    logic [7:0]  free_head_reg;
    logic [8:0]  free_total_reg;
    logic [15:0] prod_reg;
    logic [7:0]  cur_reg;
    logic [8:0]  cnt_reg;
    logic [1:0]  wst_reg;
    logic        cur_more, link_bad, self_long;
    logic [7:0]  cur_link;
    logic [1:0]  cur_flag;
    logic [7:0]  pop_idx;
    logic [7:0]  slot;
    logic [7:0]  rd_addr;
    logic [1:0]  rd_flag_reg;
    logic [7:0]  rd_link_reg;

    logic [1:0]  res_status;
    logic [7:0]  res_index;
    logic [31:0] res_length;
    logic [8:0]  res_released;

    // descriptors in use for a queue_size_log2 value
    function automatic logic [8:0] n_of(input logic [3:0] l);
        logic [3:0] c;
        logic [8:0] n;
        c = l;
        if (c < 4'd1) c = 4'd1;
        if (c > 4'd8) c = 4'd8;
        n = 9'd1 << c;
        if (n > 9'(TD)) n = 9'(TD);
        return n;
    endfunction

    assign n_val = n_of(qlog_reg);
    assign mask  = 8'(n_val - 9'd1);

    // table read port: next walk link while walking, else pop index or walk head
    assign pop_idx  = free_head_reg & mask;
    assign slot     = prod_reg[7:0] & mask;
    assign rd_addr  = ctl.walk_step ? rd_link_reg :
                      ((cmd_reg == CMD_ALLOC) ? pop_idx : cur_reg);
    assign cur_flag = rd_flag_reg;
    assign cur_link = rd_link_reg;
    assign cur_more = (cur_flag & FLAG_NEXT) != 2'b00;
    assign link_bad = {1'b0, cur_link} >= n_val;
    assign self_long = (cur_link == cur_reg) || ((cnt_reg + 9'd1) >= n_val);

    assign stat.rebuild_busy = rb_busy_reg;
    assign stat.cmd       = cmd_reg;
    assign stat.head_bad  = {1'b0, head_reg} >= n_val;
    assign stat.empty     = free_total_reg == 9'd0;
    assign stat.walk      = (cmd_reg == CMD_RELEASE) || auto_reg;
    assign stat.walk_done = !cur_more || link_bad || self_long;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlog_reg       <= 4'd8;
            auto_reg       <= 1'b1;
            rb_busy_reg    <= 1'b1;
            rb_ptr_reg     <= '0;
            free_head_reg  <= '0;
            free_total_reg <= 9'(TD);
            prod_reg       <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_QSIZE)
            begin
                qlog_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_AUTO)
            begin
                auto_reg <= cfg_data[0];
            end
            if (ctl.rebuild)
            begin
                rb_busy_reg    <= 1'b1;
                rb_ptr_reg     <= '0;
                free_head_reg  <= '0;
                free_total_reg <= n_of(cfg_data);
                prod_reg       <= '0;
            end
            else
            begin
                if (rb_busy_reg)
                begin
                    rb_ptr_reg <= rb_ptr_reg + 1'b1;
                    if (rb_ptr_reg == TW'(TD - 1)) rb_busy_reg <= 1'b0;
                end
                if (ctl.alloc && free_total_reg != 9'd0)
                begin
                    free_head_reg  <= rd_link_reg;
                    free_total_reg <= free_total_reg - 9'd1;
                end
                else if (ctl.walk_step)
                begin
                    free_head_reg <= cur_reg;
                    if (free_total_reg < n_val) free_total_reg <= free_total_reg + 9'd1;
                end
                if (ctl.publish && !stat.head_bad)
                begin
                    prod_reg <= prod_reg + 16'd1;
                end
            end
        end
    end

    // descriptor table and ring, one write port each
    always_ff @(posedge clk)
    begin
        if (rb_busy_reg)
        begin
            flag_mem[rb_ptr_reg] <= FLAG_NEXT;
            link_mem[rb_ptr_reg] <= 8'({1'b0, rb_ptr_reg} + 1);
        end
        else if (ctl.alloc && free_total_reg != 9'd0)
        begin
            addr_mem[pop_idx[TW-1:0]] <= addr_reg;
            len_mem[pop_idx[TW-1:0]]  <= blen_reg;
            flag_mem[pop_idx[TW-1:0]] <= fl_reg;
            link_mem[pop_idx[TW-1:0]] <= nx_reg;
        end
        else if (ctl.walk_step)
        begin
            flag_mem[cur_reg[TW-1:0]] <= FLAG_NEXT;
            link_mem[cur_reg[TW-1:0]] <= free_head_reg;
        end
        if (ctl.publish && !stat.head_bad)
        begin
            ring_mem[slot[TW-1:0]] <= head_reg;
        end
    end

    // registered table read
    always_ff @(posedge clk)
    begin
        rd_flag_reg <= flag_mem[rd_addr[TW-1:0]];
        rd_link_reg <= link_mem[rd_addr[TW-1:0]];
    end

    always_comb
    begin
        res_status   = ST_OK;
        res_index    = '0;
        res_length   = '0;
        res_released = '0;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                if (stat.empty) res_status = ST_NO_FREE;
                else res_index = pop_idx;
            end
            CMD_PUBLISH:
            begin
                if (stat.head_bad) res_status = ST_RANGE;
                else res_index = slot;
            end
            default:
            begin
                res_index = head_reg;
                if (cmd_reg == CMD_COMPLETE) res_length = ulen_reg;
                if (stat.head_bad) res_status = ST_RANGE;
                else if (stat.walk)
                begin
                    res_status   = wst_reg;
                    res_released = cnt_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg  <= command;
            addr_reg <= buf_addr;
            blen_reg <= buf_len;
            fl_reg   <= desc_flags;
            nx_reg   <= next_index;
            head_reg <= desc_index;
            ulen_reg <= used_len;
            cur_reg  <= desc_index;
            cnt_reg  <= '0;
            wst_reg  <= ST_OK;
        end
        else if (ctl.walk_step)
        begin
            cnt_reg <= cnt_reg + 9'd1;
            cur_reg <= cur_link;
            if (!cur_more) wst_reg <= ST_OK;
            else if (link_bad) wst_reg <= ST_RANGE;
            else if (self_long) wst_reg <= ST_TOO_LONG;
        end
        if (ctl.finish)
        begin
            index    <= res_index;
            length   <= res_length;
            released <= res_released;
            status   <= res_status;
        end
    end

    // totals reflect commits made in the finish cycle
    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            free_count <= (cmd_reg == CMD_ALLOC && !stat.empty) ?
                          free_total_reg - 9'd1 : free_total_reg;
            avail_idx  <= (cmd_reg == CMD_PUBLISH && !stat.head_bad) ?
                          prod_reg + 16'd1 : prod_reg;
        end
    end

endmodule

/* rtl/vqdm_ctrl.sv */
module vqdm_ctrl
    import vqdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  logic       cfg_qsize_we,
    input  vqdm_stat_t stat,
    output vqdm_cmd_t  ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == S_IDLE) && !stat.rebuild_busy && !cfg_qsize_we;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        ctl        = '0;
        ctl.rebuild = cfg_qsize_we;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctl.start  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.cmd[1] && !stat.head_bad && stat.walk) state_next = S_WALK;
                else state_next = S_DONE;
            end
            S_WALK:
            begin
                ctl.walk_step = 1'b1;
                if (stat.walk_done) state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the result register to be free
                if (!ov_reg || out_ready)
                begin
                    ctl.finish  = 1'b1;
                    ctl.alloc   = stat.cmd == CMD_ALLOC;
                    ctl.publish = stat.cmd == CMD_PUBLISH;
                    ov_next     = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

/* rtl/virtqueue_descriptor_manager.sv */
// channel | signals                               | direction
// input   | in_valid/in_ready + command fields    | into block
// result  | out_valid/out_ready + status fields   | out of block
// config  | cfg_valid/cfg_ready, cfg_index/data   | into block
// allocate and publish: accept, then EXEC, then DONE, which registers the result; input is taken again in IDLE
// release and complete: EXEC, then a chain walk in WALK at one descriptor per cycle, then DONE;
// the walk runs for release, or for complete with auto release set, when the head is in range
// after reset, or a queue_size_log2 write, a rebuild sweep over min(QUEUE_DEPTH, 256)
// table entries (256 by default) holds off input
// a stalled result holds in its output register; the next item is accepted meanwhile
module virtqueue_descriptor_manager
    import vqdm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [63:0] buf_addr,
    input  logic [31:0] buf_len,
    input  logic [1:0]  desc_flags,
    input  logic [7:0]  next_index,
    input  logic [7:0]  desc_index,
    input  logic [31:0] used_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  index,
    output logic [31:0] length,
    output logic [8:0]  released,
    output logic [8:0]  free_count,
    output logic [15:0] avail_idx,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    vqdm_cmd_t  ctl;
    vqdm_stat_t stat;
    logic       cfg_we;

    // config transactions always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    vqdm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cfg_qsize_we (cfg_we && cfg_index == REG_QSIZE),
        .stat         (stat),
        .ctl          (ctl)
    );

    vqdm_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .buf_addr   (buf_addr),
        .buf_len    (buf_len),
        .desc_flags (desc_flags),
        .next_index (next_index),
        .desc_index (desc_index),
        .used_len   (used_len),
        .status     (status),
        .index      (index),
        .length     (length),
        .released   (released),
        .free_count (free_count),
        .avail_idx  (avail_idx)
    );

endmodule

/* rtl/vqdm_checker.sv */
module vqdm_checker
    import vqdm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [8:0]  released,
    input logic [8:0]  free_count,
    input logic [31:0] length
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken too early");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> free_count <= 9'd256 && released <= 9'd256)
        else $error("count out of range");

    a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NO_FREE |-> released == 9'd0 && length == 32'd0)
        else $error("exhausted allocate reported work");

endmodule

bind virtqueue_descriptor_manager vqdm_checker u_vqdm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .released   (released),
    .free_count (free_count),
    .length     (length)
);
